[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define KLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked across reset.
`define KLA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/kla_pkg.sv]
package kla_pkg;

    // Fixed-point formats of the probabilities and of the divergence sum.
    localparam int PROB_FRAC_BITS = 16;
    localparam int SUM_FRAC_BITS  = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int SUM_W          = 32;

    // Logarithm unit: signed Q.24 result, Q1.30 mantissa.
    localparam int LOG_FRAC  = 24;
    localparam int LOG_INT_W = 6;
    localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
    localparam int MANT_FRAC = 30;
    localparam int MANT_W    = MANT_FRAC + 1;
    localparam int E_W       = $clog2(PROB_W);
    localparam int SH_W      = $clog2(MANT_FRAC + 1);
    localparam int CNT_W     = $clog2(LOG_FRAC);

    // Shared multiplier and the product chain behind it.
    localparam int MUL_W = 32;
    localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam int LN_W        = 38;
    localparam int HI_W        = 32;
    localparam int ROUND_SHIFT = PROB_FRAC_BITS + 32 - SUM_FRAC_BITS;
    localparam int TERM_W      = 2 * MUL_W - ROUND_SHIFT;
    localparam int ACC_W       = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 2;

    // One probability pair.
    typedef struct packed {
        logic [PROB_W-1:0] p_value;
        logic [PROB_W-1:0] q_value;
        logic              last_element;
    } kla_in_t;

    // One divergence result.
    typedef struct packed {
        logic signed [SUM_W-1:0] kl_sum;
        logic                    error_flag;
    } kla_out_t;

endpackage

[hw/rtl/kl_divergence_accumulator_core.sv]
// Channel | Direction | Signals                        | Beat
// --------+-----------+--------------------------------+-------------------------------
// in      | input     | in_valid, in_ready, in_data    | one (p, q, last) pair
// out     | output    | out_valid, out_ready, out_data | divergence sum and error flag
//
// A pair with p and q both above zero runs from its beat to the next ready cycle through
// the beat cycle, then two logarithms of 24 squaring steps each on the one
// shared 32x32 multiplier, plus normalize, difference, ln 2 scaling, two partial
// products, rounding, accumulation and finish steps. A pair with p zero, or with
// q zero, goes from the beat cycle straight to the finish step.
// Reset clears the sum, the error flag and the output register at once.
// A last pair waits in its finish step while an earlier result is not taken.
module kl_divergence_accumulator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kla_pkg::kla_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kla_pkg::kla_out_t  out_data
);
    import kla_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQ,
        S_DIFF,
        S_LN,
        S_PLO,
        S_PHI,
        S_RND,
        S_ACC,
        S_FIN
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - 1;
    localparam logic [2*MUL_W-1:0]      HALF    = (2*MUL_W)'(1) << (ROUND_SHIFT - 1);

    state_t                    state_reg;
    logic [PROB_W-1:0]         p_reg;
    logic [PROB_W-1:0]         q_reg;
    logic                      last_reg;
    logic                      op_q_reg;
    logic [E_W-1:0]            e_reg;
    logic [MANT_W-1:0]         m_reg;
    logic [LOG_FRAC-1:0]       frac_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [LOG_W-1:0]   lp_reg;
    logic signed [LOG_W-1:0]   lq_reg;
    logic                      neg_reg;
    logic [LOG_W-1:0]          mag_reg;
    logic [LN_W-1:0]           ln_reg;
    logic [2*MUL_W-1:0]        prod_lo_reg;
    logic [HI_W-1:0]           prod_hi_reg;
    logic [TERM_W-1:0]         term_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      sticky_reg;
    logic                      out_valid_reg;
    kla_out_t                  out_data_reg;

    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [2*MUL_W-1:0]        mul_p;
    logic [PROB_W-1:0]         norm_x;
    logic [E_W-1:0]            e_next;
    logic [MANT_W-1:0]         m_init;
    logic [MANT_W:0]           sq;
    logic [MANT_W-1:0]         m_next;
    logic [LOG_FRAC-1:0]       frac_next;
    logic signed [LOG_INT_W-1:0] log_int;
    logic signed [LOG_W-1:0]   log_next;
    logic signed [LOG_W:0]     diff;
    logic [2*MUL_W-1:0]        prod_rnd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SUM_W-1:0]   sum_next;
    logic                      out_free;
    logic                      out_load;

    // Position of the leading one; the operand is known to be nonzero.
    function automatic logic [E_W-1:0] msb_pos(input logic [PROB_W-1:0] x);
        logic [E_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < PROB_W; b++)
        begin
            if (x[b])
            begin
                pos = E_W'(b);
            end
        end
        return pos;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_LN:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = LN2_Q32;
            end
            S_PLO:
            begin
                mul_a = MUL_W'(p_reg);
                mul_b = ln_reg[MUL_W-1:0];
            end
            S_PHI:
            begin
                mul_a = MUL_W'(p_reg);
                mul_b = MUL_W'(ln_reg[LN_W-1:MUL_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    // Mantissa normalization to Q1.30.
    assign norm_x = op_q_reg ? q_reg : p_reg;
    assign e_next = msb_pos(norm_x);
    assign m_init = MANT_W'(norm_x) << (SH_W'(MANT_FRAC) - SH_W'(e_next));

    // One squaring step: a square at or above two yields a one and is halved.
    assign sq        = mul_p[MANT_FRAC +: MANT_W + 1];
    assign m_next    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
    assign frac_next = {frac_reg[LOG_FRAC-2:0], sq[MANT_W]};
    assign log_int   = LOG_INT_W'(e_reg) - LOG_INT_W'(PROB_FRAC_BITS);
    assign log_next  = $signed({log_int, frac_next});

    // Log difference, rounding and saturating accumulation.
    assign diff     = (LOG_W+1)'(lp_reg) - (LOG_W+1)'(lq_reg);
    assign prod_rnd = prod_lo_reg + {prod_hi_reg, (2*MUL_W-HI_W)'(0)} + HALF;

    always_comb
    begin
        logic signed [ACC_W-1:0] sum_ext;
        logic signed [ACC_W-1:0] term_ext;
        sum_ext  = ACC_W'(sum_reg);
        term_ext = $signed({(ACC_W-TERM_W)'(0), term_reg});
        acc      = neg_reg ? sum_ext - term_ext : sum_ext + term_ext;
        priority if (acc > ACC_MAX)
        begin
            sum_next = SUM_W'(ACC_MAX);
        end
        else if (acc < ACC_MIN)
        begin
            sum_next = SUM_W'(ACC_MIN);
        end
        else
        begin
            sum_next = acc[SUM_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_FIN) && last_reg && out_free;

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_reg         <= '0;
            q_reg         <= '0;
            last_reg      <= 1'b0;
            op_q_reg      <= 1'b0;
            e_reg         <= '0;
            m_reg         <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            lp_reg        <= '0;
            lq_reg        <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ln_reg        <= '0;
            prod_lo_reg   <= '0;
            prod_hi_reg   <= '0;
            term_reg      <= '0;
            sum_reg       <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // A new result replaces the one taken in the same cycle.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        p_reg    <= in_data.p_value;
                        q_reg    <= in_data.q_value;
                        last_reg <= in_data.last_element;
                        op_q_reg <= 1'b0;
                        if (in_data.p_value == '0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (in_data.q_value == '0)
                        begin
                            sticky_reg <= 1'b1;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    e_reg     <= e_next;
                    m_reg     <= m_init;
                    frac_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    m_reg    <= m_next;
                    frac_reg <= frac_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LOG_FRAC - 1))
                    begin
                        if (!op_q_reg)
                        begin
                            lp_reg    <= log_next;
                            op_q_reg  <= 1'b1;
                            state_reg <= S_NORM;
                        end
                        else
                        begin
                            lq_reg    <= log_next;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF:
                begin
                    neg_reg   <= diff[LOG_W];
                    mag_reg   <= diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
                    state_reg <= S_LN;
                end
                S_LN:
                begin
                    ln_reg    <= mul_p[LOG_FRAC +: LN_W];
                    state_reg <= S_PLO;
                end
                S_PLO:
                begin
                    prod_lo_reg <= mul_p;
                    state_reg   <= S_PHI;
                end
                S_PHI:
                begin
                    prod_hi_reg <= mul_p[HI_W-1:0];
                    state_reg   <= S_RND;
                end
                S_RND:
                begin
                    term_reg  <= TERM_W'(prod_rnd >> ROUND_SHIFT);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_data_reg.kl_sum     <= sum_reg;
                        out_data_reg.error_flag <= sticky_reg;
                        sum_reg                 <= '0;
                        sticky_reg              <= 1'b0;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hw/rtl/kla_checker.sv]
`include "assert_macros.svh"

module kla_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input kla_pkg::kla_out_t out_data
);
    // A result that is not taken holds its beat.
    `KLA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

    // Reset empties the output register.
    `KLA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result present after reset")

    // Every accepted pair makes the block busy in the cycle after it.
    `KLA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken on consecutive cycles")

    // A new result is loaded only from the finish step, never while idle.
    `KLA_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result appeared while idle")

endmodule

bind kl_divergence_accumulator_core kla_checker u_kla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
